// ===== src/bfip_pkg.sv =====
// ----------------------------------------------------------------------------
// bfip_pkg
// Types, constants and helpers shared by the bloom filter insert/probe engine.
// ----------------------------------------------------------------------------
package bfip_pkg;

   localparam int unsigned STORE_BITS_DEFAULT = 65536;
   localparam int unsigned MAX_HASHES_DEFAULT = 32;

   localparam int M_W    = 17;   // bit count register width
   localparam int K_W    = 6;    // hash count register width
   localparam int KB_W   = 4;    // key byte count width
   localparam int IDX_W  = 13;   // byte index width
   localparam int CSR_W  = 2;    // config index width
   localparam int KEY_MAX_BYTES = 8;
   localparam int MIN_BITS      = 8;

   localparam logic [63:0] FNV_BASIS   = 64'hCBF29CE484222325;
   localparam logic [63:0] FNV_PRIME_L = 64'h00000000000001B3;  // prime = 2^40 + this
   localparam int          FNV_PRIME_SHIFT = 40;
   localparam logic [63:0] SEED_SALT   = 64'h9E3779B97F4A7C15;

   localparam int DIV_BITS_PER_CYCLE = 4;
   localparam int DIV_STEPS = 64 / DIV_BITS_PER_CYCLE;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int QDEPTH = 2;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [CSR_W-1:0] CSR_BIT_COUNT  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_HASH_COUNT = 2'd1;
   localparam logic [CSR_W-1:0] CSR_HASH_SEED  = 2'd2;

   localparam logic ANS_PROBE = 1'b0;
   localparam logic ANS_READ  = 1'b1;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_PROBE  = 2'd1,
      CMD_MERGE  = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [63:0]      key;
      logic [KB_W-1:0]  key_bytes;
      logic [IDX_W-1:0] byte_index;
      logic [7:0]       byte_value;
   } req_type;

   typedef struct packed {
      logic       answer_kind;
      logic       maybe_present;
      logic [7:0] read_byte;
   } rsp_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [63:0]      h1;
      logic [63:0]      h2;
      logic [IDX_W-1:0] byte_index;
      logic [7:0]       byte_value;
   } work_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_HASH,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_DIV,
      B_HREAD,
      B_HUPD,
      B_BREAD,
      B_BUPD
   } back_state_type;

   // one fnv-1a round: xor the byte, multiply by 2^40 + 0x1b3
   function automatic logic [63:0] fnv_round(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << FNV_PRIME_SHIFT) + (x * FNV_PRIME_L);
   endfunction

endpackage

// ===== src/bfip_ram.sv =====
// ----------------------------------------------------------------------------
// bfip_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bfip_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bfip_front.sv =====
// ----------------------------------------------------------------------------
// bfip_front
// Accepts request beats and, for insert and probe, runs both seeded fnv-1a
// hashes, one key byte a cycle, then hands the classified work item to the queue.
// ----------------------------------------------------------------------------
module bfip_front import bfip_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic [63:0] hash_seed,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        push_valid,
   input  logic        push_ready,
   output work_type    push_data
);

   front_state_type  state_ff, state_in;
   logic [63:0]      key_ff, key_in;
   logic [63:0]      h1_ff, h1_in;
   logic [63:0]      h2_ff, h2_in;
   logic [KB_W-1:0]  cnt_ff, cnt_in;
   cmd_type          cmd_ff, cmd_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       val_ff, val_in;
   logic [KB_W-1:0]  kb_eff;

   always_comb begin
      if (req_data.key_bytes == '0) begin
         kb_eff = KB_W'(1);
      end else if (req_data.key_bytes > KB_W'(KEY_MAX_BYTES)) begin
         kb_eff = KB_W'(KEY_MAX_BYTES);
      end else begin
         kb_eff = req_data.key_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      key_ff <= key_in;
      h1_ff  <= h1_in;
      h2_ff  <= h2_in;
      cnt_ff <= cnt_in;
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      val_ff <= val_in;
   end

   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      h1_in      = h1_ff;
      h2_in      = h2_ff;
      cnt_in     = cnt_ff;
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      val_in     = val_ff;
      req_ready  = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_ready = enable;
            if (enable && req_valid) begin
               key_in = req_data.key;
               cmd_in = req_data.cmd;
               idx_in = req_data.byte_index;
               val_in = req_data.byte_value;
               h1_in  = FNV_BASIS ^ hash_seed;
               h2_in  = FNV_BASIS ^ hash_seed ^ SEED_SALT;
               cnt_in = kb_eff;
               if (req_data.cmd == CMD_INSERT || req_data.cmd == CMD_PROBE) begin
                  state_in = F_HASH;
               end else begin
                  state_in = F_PUSH;
               end
            end
         end
         F_HASH: begin
            h1_in  = fnv_round(h1_ff, key_ff[7:0]);
            h2_in  = fnv_round(h2_ff, key_ff[7:0]);
            key_in = key_ff >> 8;
            cnt_in = cnt_ff - KB_W'(1);
            if (cnt_ff == KB_W'(1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_comb begin
      push_data.cmd        = cmd_ff;
      push_data.h1         = h1_ff;
      push_data.h2         = h2_ff;
      push_data.byte_index = idx_ff;
      push_data.byte_value = val_ff;
   end

endmodule

// ===== src/bfip_queue.sv =====
// ----------------------------------------------------------------------------
// bfip_queue
// Two-entry queue of work items between the hashing front and the store back.
// ----------------------------------------------------------------------------
module bfip_queue import bfip_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  work_type          push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output work_type          pop_data,
   output logic [QCNT_W-1:0] count
);

   work_type            entry_ff [QDEPTH];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/bfip_back.sv =====
// ----------------------------------------------------------------------------
// bfip_back
// Reduces the hashes modulo the bit count, walks the bit positions against
// the byte store and serves merge and read beats; clears the store at reset.
// ----------------------------------------------------------------------------
module bfip_back import bfip_pkg::*; #(
   parameter int unsigned STORE_BITS = STORE_BITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [M_W-1:0] bit_count,
   input  logic [K_W-1:0] hash_count,
   input  logic           pop_valid,
   output logic           pop_ready,
   input  work_type       pop_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data,
   output logic           clear_busy
);

   localparam int unsigned STORE_BYTES = (STORE_BITS + 7) / 8;
   localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   back_state_type       state_ff, state_in;
   work_type             work_ff, work_in;
   logic [63:0]          sh1_ff, sh1_in;
   logic [63:0]          sh2_ff, sh2_in;
   logic [M_W-1:0]       r1_ff, r1_in;
   logic [M_W-1:0]       r2_ff, r2_in;
   logic [M_W-1:0]       rw_ff, rw_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [M_W-1:0]       pos_ff, pos_in;
   logic [63:0]          x_ff, x_in;
   logic [K_W-1:0]       j_ff, j_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [7:0]           wr_data, rd_data;
   logic                 out_free;
   logic                 in_range;
   logic                 bit_set;
   logic                 last_hash;
   logic [64:0]          x_sum;
   logic [M_W:0]         t_pos;
   logic [7:0]           bit_mask;

   // restoring remainder step: shift one dividend bit in, subtract if it fits
   function automatic logic [M_W-1:0] rem_step(input logic [M_W-1:0] r, input logic b,
                                                input logic [M_W-1:0] m);
      logic [M_W:0] t;
      t = {r, b};
      if (t >= {1'b0, m}) begin
         t = t - {1'b0, m};
      end
      return t[M_W-1:0];
   endfunction

   bfip_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign in_range   = 32'(work_ff.byte_index) < 32'(STORE_BYTES);
   assign bit_set    = rd_data[pos_ff[2:0]];
   assign bit_mask   = 8'(1) << pos_ff[2:0];
   assign last_hash  = (j_ff == K_W'(hash_count - K_W'(1)));
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign clear_busy = (state_ff == B_CLEAR);

   // next bit position: (h1 + (j+1)*h2) wraps at 2^64, so fold in 2^64 mod m on carry
   always_comb begin
      x_sum = {1'b0, x_ff} + {1'b0, work_ff.h2};
      t_pos = {1'b0, pos_ff} + {1'b0, r2_ff};
      if (t_pos >= {1'b0, bit_count}) begin
         t_pos = t_pos - {1'b0, bit_count};
      end
      if (x_sum[64]) begin
         if (t_pos >= {1'b0, rw_ff}) begin
            t_pos = t_pos - {1'b0, rw_ff};
         end else begin
            t_pos = t_pos + {1'b0, bit_count} - {1'b0, rw_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff <= work_in;
      sh1_ff  <= sh1_in;
      sh2_ff  <= sh2_in;
      r1_ff   <= r1_in;
      r2_ff   <= r2_in;
      rw_ff   <= rw_in;
      step_ff <= step_in;
      pos_ff  <= pos_in;
      x_ff    <= x_in;
      j_ff    <= j_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      sh1_in       = sh1_ff;
      sh2_in       = sh2_ff;
      r1_in        = r1_ff;
      r2_in        = r2_ff;
      rw_in        = rw_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      x_in         = x_ff;
      j_in         = j_ff;
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = AW'(pos_ff[M_W-1:3]);
      wr_data      = rd_data | bit_mask;
      rd_en        = 1'b0;
      rd_addr      = AW'(pos_ff[M_W-1:3]);
      unique case (state_ff)
         B_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + AW'(1);
            if (32'(clr_ff) == STORE_BYTES - 1) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               work_in = pop_data;
               sh1_in  = pop_data.h1;
               sh2_in  = pop_data.h2;
               x_in    = pop_data.h1;
               r1_in   = '0;
               r2_in   = '0;
               rw_in   = M_W'(1);
               step_in = '0;
               j_in    = '0;
               if (pop_data.cmd == CMD_INSERT || pop_data.cmd == CMD_PROBE) begin
                  state_in = B_DIV;
               end else begin
                  state_in = B_BREAD;
               end
            end
         end
         B_DIV: begin
            for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
               r1_in  = rem_step(r1_in, sh1_in[63], bit_count);
               r2_in  = rem_step(r2_in, sh2_in[63], bit_count);
               rw_in  = rem_step(rw_in, 1'b0, bit_count);
               sh1_in = sh1_in << 1;
               sh2_in = sh2_in << 1;
            end
            step_in = step_ff + DIV_CNT_W'(1);
            if (step_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               pos_in   = r1_in;
               state_in = B_HREAD;
            end
         end
         B_HREAD: begin
            rd_en    = 1'b1;
            state_in = B_HUPD;
         end
         B_HUPD: begin
            if (work_ff.cmd == CMD_INSERT) begin
               wr_en = 1'b1;
               if (last_hash) begin
                  state_in = B_IDLE;
               end else begin
                  pos_in   = t_pos[M_W-1:0];
                  x_in     = x_sum[63:0];
                  j_in     = j_ff + K_W'(1);
                  state_in = B_HREAD;
               end
            end else if (!bit_set || last_hash) begin
               if (out_free) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.answer_kind   = ANS_PROBE;
                  rsp_in.maybe_present = bit_set;
                  rsp_in.read_byte     = '0;
                  state_in             = B_IDLE;
               end
            end else begin
               pos_in   = t_pos[M_W-1:0];
               x_in     = x_sum[63:0];
               j_in     = j_ff + K_W'(1);
               state_in = B_HREAD;
            end
         end
         B_BREAD: begin
            rd_en    = in_range;
            rd_addr  = AW'(work_ff.byte_index);
            state_in = B_BUPD;
         end
         B_BUPD: begin
            wr_addr = AW'(work_ff.byte_index);
            wr_data = rd_data | work_ff.byte_value;
            if (work_ff.cmd == CMD_MERGE) begin
               wr_en    = in_range;
               state_in = B_IDLE;
            end else if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.answer_kind   = ANS_READ;
               rsp_in.maybe_present = 1'b0;
               rsp_in.read_byte     = in_range ? rd_data : 8'd0;
               state_in             = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

endmodule

// ===== src/bloom_filter_insert_probe_top.sv =====
// ----------------------------------------------------------------------------
// bloom_filter_insert_probe_top
// Bloom filter engine with seeded fnv-1a double hashing over a byte store.
// ----------------------------------------------------------------------------
// After reset the store is cleared one byte a cycle, during which no
// request beat is taken. An insert or probe hashes its key bytes in the
// front, then in the back reduces both hashes and 2^64 modulo the bit count
// (4 remainder bits a cycle) and walks each bit position with a store read,
// then an update; a probe stops at the first clear bit. Merge and read do
// one store read, then a write or an answer. The two-entry queue lets the
// next key hash while the store walk of the previous one runs.
module bloom_filter_insert_probe_top import bfip_pkg::*; #(
   parameter int unsigned STORE_BITS = STORE_BITS_DEFAULT,
   parameter int unsigned MAX_HASHES = MAX_HASHES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_index,
   input  logic [63:0]      csr_data
);

   logic [M_W-1:0]    bit_count_ff, bit_count_in;
   logic [K_W-1:0]    hash_count_ff, hash_count_in;
   logic [63:0]       hash_seed_ff, hash_seed_in;
   logic [M_W-1:0]    m_eff;
   logic [K_W-1:0]    k_eff;
   logic              clear_busy;
   logic              push_valid, push_ready;
   work_type          push_data;
   logic              pop_valid, pop_ready;
   work_type          pop_data;
   logic [QCNT_W-1:0] q_count;

   assign csr_ready = 1'b1;

   always_comb begin
      bit_count_in  = bit_count_ff;
      hash_count_in = hash_count_ff;
      hash_seed_in  = hash_seed_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BIT_COUNT:  bit_count_in  = csr_data[M_W-1:0];
            CSR_HASH_COUNT: hash_count_in = csr_data[K_W-1:0];
            CSR_HASH_SEED:  hash_seed_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff  <= M_W'(65536);
         hash_count_ff <= K_W'(1);
         hash_seed_ff  <= '0;
      end else begin
         bit_count_ff  <= bit_count_in;
         hash_count_ff <= hash_count_in;
         hash_seed_ff  <= hash_seed_in;
      end
   end

   always_comb begin
      if (bit_count_ff < M_W'(MIN_BITS)) begin
         m_eff = M_W'(MIN_BITS);
      end else if (32'(bit_count_ff) > 32'(STORE_BITS)) begin
         m_eff = M_W'(STORE_BITS);
      end else begin
         m_eff = bit_count_ff;
      end
      if (hash_count_ff == '0) begin
         k_eff = K_W'(1);
      end else if (32'(hash_count_ff) > 32'(MAX_HASHES)) begin
         k_eff = K_W'(MAX_HASHES);
      end else begin
         k_eff = hash_count_ff;
      end
   end

   bfip_front u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (!clear_busy),
      .hash_seed  (hash_seed_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   bfip_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .count      (q_count)
   );

   bfip_back #(
      .STORE_BITS (STORE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .bit_count  (m_eff),
      .hash_count (k_eff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .clear_busy (clear_busy)
   );

   // no request beat taken while the store is being cleared
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !clear_busy)
      else $error("request accepted during store clear");

   // queue occupancy stays within its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_W'(QDEPTH))
      else $error("queue occupancy out of range");

   // read answers carry no presence flag, probe answers carry no byte
   a_rsp_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.answer_kind == ANS_READ && !rsp_data.maybe_present) ||
                     (rsp_data.answer_kind == ANS_PROBE && rsp_data.read_byte == 8'd0)))
      else $error("malformed response beat");

   // nothing can come out while the store is still being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !rsp_valid)
      else $error("response during store clear");

endmodule
